[design/pcrs_pkg.sv]
`default_nettype none

package pcrs_pkg;

  localparam int CONF_W    = 17;
  localparam int CFG_W     = 16;
  localparam int KIND_W    = 3;
  localparam int MODE_W    = 2;
  localparam int MASK_W    = 16;
  localparam int RANK_W    = 3;
  localparam int OUTCOME_W = 3;
  localparam int REASON_W  = 3;
  localparam int INDEX_W   = 4;
  localparam int COUNT_W   = 5;

  typedef logic signed [CONF_W-1:0] conf_t;
  typedef logic [CFG_W-1:0]         cfg_t;
  typedef logic [KIND_W-1:0]        kind_t;
  typedef logic [MODE_W-1:0]        mode_t;
  typedef logic [MASK_W-1:0]        mask_t;
  typedef logic [RANK_W-1:0]        rank_t;
  typedef logic [OUTCOME_W-1:0]     outcome_t;
  typedef logic [REASON_W-1:0]      reason_t;
  typedef logic [INDEX_W-1:0]       index_t;
  typedef logic [COUNT_W-1:0]       count_t;

  localparam cfg_t CONF_MIN_RESET = 16'd21299;  // 0.65 in unsigned Q1.15

  localparam kind_t KIND_LINE         = 3'd0;
  localparam kind_t KIND_CROSS_EXIT   = 3'd1;
  localparam kind_t KIND_CIRCLE_LEFT  = 3'd2;
  localparam kind_t KIND_CIRCLE_RIGHT = 3'd3;
  localparam kind_t KIND_ROADBLOCK    = 3'd4;
  localparam kind_t KIND_ML_GROUNDED  = 3'd5;

  localparam mode_t MODE_INTERVAL_CENTER = 2'd0;
  localparam mode_t MODE_HOLD_LAST       = 2'd1;

  localparam reason_t REASON_NONE      = 3'd0;
  localparam reason_t REASON_BAD_CONF  = 3'd1;
  localparam reason_t REASON_HOLD_MODE = 3'd2;
  localparam reason_t REASON_NONE_MODE = 3'd3;
  localparam reason_t REASON_NO_LEAD   = 3'd4;
  localparam reason_t REASON_GAP       = 3'd5;
  localparam reason_t REASON_NONFINITE = 3'd6;

  localparam outcome_t OUTCOME_NOTHING  = 3'd0;
  localparam outcome_t OUTCOME_SPECIAL  = 3'd1;
  localparam outcome_t OUTCOME_LINE     = 3'd2;
  localparam outcome_t OUTCOME_AMBIG    = 3'd3;
  localparam outcome_t OUTCOME_NO_VALID = 3'd4;

  function automatic rank_t kind_rank(input kind_t kind);
    rank_t r;
    case (kind)
      KIND_ROADBLOCK:    r = 3'd5;
      KIND_CIRCLE_LEFT:  r = 3'd4;
      KIND_CIRCLE_RIGHT: r = 3'd4;
      KIND_CROSS_EXIT:   r = 3'd3;
      KIND_ML_GROUNDED:  r = 3'd2;
      KIND_LINE:         r = 3'd1;
      default:           r = 3'd0;  // unused kind codes
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[design/priority_confidence_reference_selector.sv]
// Reference selector: picks one candidate out of a list of candidates.
// Input channel (in_valid/in_ready) carries one candidate per item, in list
// order; in_is_last closes the list. Only the closing item produces a result
// on the output channel (out_valid/out_ready), one result per list.
// The cfg_wr_en/cfg_wr_data port sets the special-kind confidence threshold;
// write it only between lists.
// The closing item is taken into the input register; once it can advance, the
// result lands in the result register and is shown on the output channel.
// Throughput: one item per cycle unless a closing item waits on a stalled result;
// each item is checked and folded into the running bests in a single pass.
// Items beyond MAX_CANDIDATES are dropped, but is_last still closes the list.
// Reset: all list state is cleared, the threshold returns to 0.65, no result
// is pending. After each result the list state clears on its own.
// Receiver stall: a result waits in the output register; non-closing items
// keep flowing, a closing item waits in the input register and in_ready
// drops until the pending result is taken.
`default_nettype none

module priority_confidence_reference_selector #(
  parameter int MAX_CANDIDATES = 16,
  parameter int PATH_SAMPLES   = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,

  input  wire                    cfg_wr_en,
  input  pcrs_pkg::cfg_t         cfg_wr_data,

  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    in_present,
  input  pcrs_pkg::kind_t        in_kind,
  input  pcrs_pkg::conf_t        in_confidence,
  input  wire                    in_confidence_nonfinite,
  input  pcrs_pkg::mode_t        in_path_mode,
  input  pcrs_pkg::mask_t        in_sample_present_mask,
  input  pcrs_pkg::mask_t        in_sample_nonfinite_mask,
  input  wire                    in_is_last,

  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   out_selected_present,
  output pcrs_pkg::index_t       out_selected_index,
  output pcrs_pkg::kind_t        out_selected_kind,
  output pcrs_pkg::outcome_t     out_outcome,
  output pcrs_pkg::count_t       out_valid_count,
  output pcrs_pkg::reason_t      out_first_reject_reason
);
  import pcrs_pkg::*;

  localparam int PW = $clog2(MAX_CANDIDATES + 1);
  localparam int IW = $clog2(MAX_CANDIDATES);
  localparam int PS = PATH_SAMPLES;
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_CANDIDATES);
  localparam logic [PS-1:0] PS_ONE    = PS'(1);

  cfg_t cfg_r;

  // input register
  logic  s1_valid_r;
  logic  s1_present_r;
  kind_t s1_kind_r;
  conf_t s1_conf_r;
  logic  s1_nonfinite_r;
  mode_t s1_mode_r;
  mask_t s1_pmask_r;
  mask_t s1_nmask_r;
  logic  s1_last_r;

  // list state
  logic [PW-1:0] pos_r, pos_nxt;
  logic          line_found_r, line_found_nxt;
  logic [IW-1:0] line_idx_r, line_idx_nxt;
  conf_t         line_conf_r, line_conf_nxt;
  logic          sp_found_r, sp_found_nxt;
  logic [IW-1:0] sp_idx_r, sp_idx_nxt;
  rank_t         sp_rank_r, sp_rank_nxt;
  conf_t         sp_conf_r, sp_conf_nxt;
  kind_t         sp_kind_r, sp_kind_nxt;
  logic          tie_r, tie_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  reason_t       reject_r, reject_nxt;

  // result register
  logic     out_valid_r;
  logic     res_present_r;
  index_t   res_index_r;
  kind_t    res_kind_r;
  outcome_t res_outcome_r;
  count_t   res_count_r;
  reason_t  res_reason_r;

  logic     adv;
  logic     take;
  reason_t  why;
  rank_t    rank;
  logic [PS+MASK_W-1:0] pm_ext, nm_ext;
  logic [PS-1:0] pm, nm, lead;
  logic     gap, nonfin;
  logic     res_present;
  logic [IW-1:0] res_idx;
  kind_t    res_kind;
  outcome_t res_outcome;
  logic [IW+INDEX_W-1:0] res_idx_ext;
  logic [PW+COUNT_W-1:0] acc_ext;

  assign adv      = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign take     = s1_present_r && (pos_r < POS_LIMIT);

  // sample mask checks: contiguous run from the leading sample
  assign pm_ext = {{PS{1'b0}}, s1_pmask_r};
  assign nm_ext = {{PS{1'b0}}, s1_nmask_r};
  assign pm     = pm_ext[PS-1:0];
  assign nm     = nm_ext[PS-1:0];
  assign lead   = (pm ^ (pm + PS_ONE)) & pm;
  assign gap    = |(pm & ~lead);
  assign nonfin = |(nm & lead);

  always_comb begin
    if (s1_nonfinite_r || s1_conf_r[CONF_W-1]) begin
      why = REASON_BAD_CONF;
    end else if (s1_mode_r == MODE_HOLD_LAST) begin
      why = REASON_HOLD_MODE;
    end else if (s1_mode_r != MODE_INTERVAL_CENTER) begin
      why = REASON_NONE_MODE;
    end else if (!pm[0]) begin
      why = REASON_NO_LEAD;
    end else if (nonfin) begin
      why = REASON_NONFINITE;
    end else if (gap) begin
      why = REASON_GAP;
    end else begin
      why = REASON_NONE;
    end
  end

  assign rank = kind_rank(s1_kind_r);

  always_comb begin
    pos_nxt        = pos_r;
    line_found_nxt = line_found_r;
    line_idx_nxt   = line_idx_r;
    line_conf_nxt  = line_conf_r;
    sp_found_nxt   = sp_found_r;
    sp_idx_nxt     = sp_idx_r;
    sp_rank_nxt    = sp_rank_r;
    sp_conf_nxt    = sp_conf_r;
    sp_kind_nxt    = sp_kind_r;
    tie_nxt        = tie_r;
    acc_nxt        = acc_r;
    reject_nxt     = reject_r;
    if (pos_r < POS_LIMIT) begin
      pos_nxt = pos_r + PW'(1);
    end
    if (take && why != REASON_NONE) begin
      if (reject_r == REASON_NONE) begin
        reject_nxt = why;
      end
    end else if (take) begin
      acc_nxt = acc_r + PW'(1);
      if (s1_kind_r == KIND_LINE) begin
        if (!line_found_r || s1_conf_r > line_conf_r) begin
          line_found_nxt = 1'b1;
          line_idx_nxt   = pos_r[IW-1:0];
          line_conf_nxt  = s1_conf_r;
        end
      end else if (s1_conf_r[CFG_W-1:0] >= cfg_r) begin
        // valid confidence is non-negative, so the low bits compare unsigned
        if (!sp_found_r || rank > sp_rank_r) begin
          sp_found_nxt = 1'b1;
          sp_idx_nxt   = pos_r[IW-1:0];
          sp_rank_nxt  = rank;
          sp_conf_nxt  = s1_conf_r;
          sp_kind_nxt  = s1_kind_r;
          tie_nxt      = 1'b0;
        end else if (rank == sp_rank_r) begin
          if (s1_conf_r > sp_conf_r) begin
            sp_idx_nxt  = pos_r[IW-1:0];
            sp_conf_nxt = s1_conf_r;
            sp_kind_nxt = s1_kind_r;
            tie_nxt     = 1'b0;
          end else if (s1_conf_r == sp_conf_r) begin
            tie_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    res_present = 1'b0;
    res_idx     = '0;
    res_kind    = KIND_LINE;
    res_outcome = OUTCOME_NOTHING;
    if (tie_nxt) begin
      res_outcome = OUTCOME_AMBIG;
    end else if (sp_found_nxt) begin
      res_present = 1'b1;
      res_idx     = sp_idx_nxt;
      res_kind    = sp_kind_nxt;
      res_outcome = OUTCOME_SPECIAL;
    end else if (line_found_nxt) begin
      res_present = 1'b1;
      res_idx     = line_idx_nxt;
      res_outcome = OUTCOME_LINE;
    end else if (reject_nxt != REASON_NONE) begin
      res_outcome = OUTCOME_NO_VALID;
    end
  end

  assign res_idx_ext = {{INDEX_W{1'b0}}, res_idx};
  assign acc_ext     = {{COUNT_W{1'b0}}, acc_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CONF_MIN_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_present_r   <= in_present;
      s1_kind_r      <= in_kind;
      s1_conf_r      <= in_confidence;
      s1_nonfinite_r <= in_confidence_nonfinite;
      s1_mode_r      <= in_path_mode;
      s1_pmask_r     <= in_sample_present_mask;
      s1_nmask_r     <= in_sample_nonfinite_mask;
      s1_last_r      <= in_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && s1_last_r)) begin
      pos_r        <= '0;
      line_found_r <= 1'b0;
      line_idx_r   <= '0;
      line_conf_r  <= '0;
      sp_found_r   <= 1'b0;
      sp_idx_r     <= '0;
      sp_rank_r    <= '0;
      sp_conf_r    <= '0;
      sp_kind_r    <= KIND_LINE;
      tie_r        <= 1'b0;
      acc_r        <= '0;
      reject_r     <= REASON_NONE;
    end else if (adv) begin
      pos_r        <= pos_nxt;
      line_found_r <= line_found_nxt;
      line_idx_r   <= line_idx_nxt;
      line_conf_r  <= line_conf_nxt;
      sp_found_r   <= sp_found_nxt;
      sp_idx_r     <= sp_idx_nxt;
      sp_rank_r    <= sp_rank_nxt;
      sp_conf_r    <= sp_conf_nxt;
      sp_kind_r    <= sp_kind_nxt;
      tie_r        <= tie_nxt;
      acc_r        <= acc_nxt;
      reject_r     <= reject_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      res_present_r <= res_present;
      res_index_r   <= res_idx_ext[INDEX_W-1:0];
      res_kind_r    <= res_kind;
      res_outcome_r <= res_outcome;
      res_count_r   <= acc_ext[COUNT_W-1:0];
      res_reason_r  <= reject_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_selected_present    = res_present_r;
  assign out_selected_index      = res_index_r;
  assign out_selected_kind       = res_kind_r;
  assign out_outcome             = res_outcome_r;
  assign out_valid_count         = res_count_r;
  assign out_first_reject_reason = res_reason_r;

endmodule

`default_nettype wire

[design/pcrs_checker.sv]
`default_nettype none

module pcrs_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_ready,
  input wire                out_selected_present,
  input pcrs_pkg::index_t   out_selected_index,
  input pcrs_pkg::kind_t    out_selected_kind,
  input pcrs_pkg::outcome_t out_outcome,
  input pcrs_pkg::reason_t  out_first_reject_reason
);
  import pcrs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_outcome)
      && $stable(out_selected_index) && $stable(out_selected_kind))
    else $error("result changed while stalled");

  // selection flag agrees with the outcome
  a_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_selected_present ==
      (out_outcome == OUTCOME_SPECIAL || out_outcome == OUTCOME_LINE))
    else $error("selected_present disagrees with outcome");

  // nothing selected means zero index and kind
  a_unselected_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_selected_present |->
      out_selected_index == '0 && out_selected_kind == KIND_LINE)
    else $error("unselected result carries index or kind");

  // line outcome carries the line kind, special outcome never does
  a_kind_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outcome == OUTCOME_LINE) ==
      (out_selected_present && out_selected_kind == KIND_LINE))
    else $error("selected kind disagrees with outcome");

  // no valid candidate is only reported when something was rejected
  a_no_valid_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == OUTCOME_NO_VALID || out_outcome == OUTCOME_NOTHING) |->
      (out_first_reject_reason != REASON_NONE) == (out_outcome == OUTCOME_NO_VALID))
    else $error("no-valid outcome disagrees with reject reason");

endmodule

bind priority_confidence_reference_selector pcrs_checker u_pcrs_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_selected_present    (out_selected_present),
  .out_selected_index      (out_selected_index),
  .out_selected_kind       (out_selected_kind),
  .out_outcome             (out_outcome),
  .out_first_reject_reason (out_first_reject_reason)
);

`default_nettype wire

[test/reference_choice_checker.sv]
`timescale 1ns / 100ps

module reference_choice_checker
  import pcrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  cfg_t     cfg_wr_data,
  input  logic     in_valid,
  input  logic     in_ready,
  input  logic     in_present,
  input  kind_t    in_kind,
  input  conf_t    in_confidence,
  input  logic     in_confidence_nonfinite,
  input  mode_t    in_path_mode,
  input  mask_t    in_sample_present_mask,
  input  mask_t    in_sample_nonfinite_mask,
  input  logic     in_is_last,
  input  logic     out_valid,
  input  logic     out_ready,
  input  logic     out_selected_present,
  input  index_t   out_selected_index,
  input  kind_t    out_selected_kind,
  input  outcome_t out_outcome,
  input  count_t   out_valid_count,
  input  reason_t  out_first_reject_reason,
  output int       fail_count,
  output int       results_owed
);

  localparam int LIST_LIMIT   = 16;
  localparam int SAMPLE_COUNT = 16;
  localparam int PRINT_LIMIT  = 50;

  typedef struct {
    logic     chosen;
    index_t   index;
    kind_t    kind;
    outcome_t outcome;
    count_t   valid_count;
    reason_t  reason;
  } choice_t;

  choice_t expected_choices[$];

  cfg_t    special_floor;
  int      list_pos;
  logic    line_seen;
  index_t  line_index;
  conf_t   line_conf;
  logic    special_seen;
  index_t  special_index;
  rank_t   special_rank;
  conf_t   special_conf;
  kind_t   special_kind;
  logic    tied;
  count_t  passed;
  reason_t first_reason;

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  task automatic report_mismatch(string what, int got, int want);
    if (fail_count < PRINT_LIMIT) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  function automatic rank_t kind_priority(kind_t kind);
    case (kind)
      KIND_ROADBLOCK:                      return 3'd5;
      KIND_CIRCLE_LEFT, KIND_CIRCLE_RIGHT: return 3'd4;
      KIND_CROSS_EXIT:                     return 3'd3;
      KIND_ML_GROUNDED:                    return 3'd2;
      KIND_LINE:                           return 3'd1;
      default:                             return 3'd0;
    endcase
  endfunction

  function automatic reason_t screen_candidate(conf_t conf, logic conf_bad, mode_t mode,
                                               mask_t sample_bits, mask_t broken_bits);
    logic hole;
    hole = 1'b0;
    if (conf_bad || conf < 0) return REASON_BAD_CONF;
    if (mode == MODE_HOLD_LAST) return REASON_HOLD_MODE;
    if (mode != MODE_INTERVAL_CENTER) return REASON_NONE_MODE;
    if (!sample_bits[0]) return REASON_NO_LEAD;
    // nonfinite flags only matter on samples that are present
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      if (!sample_bits[i]) hole = 1'b1;
      else if (hole) return REASON_GAP;
      else if (broken_bits[i]) return REASON_NONFINITE;
    end
    return REASON_NONE;
  endfunction

  task automatic clear_list();
    list_pos      = 0;
    line_seen     = 1'b0;
    line_index    = '0;
    line_conf     = '0;
    special_seen  = 1'b0;
    special_index = '0;
    special_rank  = '0;
    special_conf  = '0;
    special_kind  = KIND_LINE;
    tied          = 1'b0;
    passed        = '0;
    first_reason  = REASON_NONE;
  endtask

  task automatic fold_candidate(index_t pos, kind_t kind, conf_t conf, reason_t why);
    rank_t pri;
    pri = kind_priority(kind);
    if (why != REASON_NONE) begin
      if (first_reason == REASON_NONE) first_reason = why;
    end else begin
      passed++;
      if (kind == KIND_LINE) begin
        if (!line_seen || conf > line_conf) begin
          line_seen  = 1'b1;
          line_index = pos;
          line_conf  = conf;
        end
      end else if (conf[CONF_W-2:0] >= special_floor) begin
        // conf is known non-negative here, so the low bits compare unsigned
        if (!special_seen || pri > special_rank) begin
          special_seen  = 1'b1;
          special_index = pos;
          special_rank  = pri;
          special_conf  = conf;
          special_kind  = kind;
          tied          = 1'b0;
        end else if (pri == special_rank) begin
          if (conf > special_conf) begin
            special_index = pos;
            special_conf  = conf;
            special_kind  = kind;
            tied          = 1'b0;
          end else if (conf == special_conf) begin
            tied = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic close_list();
    choice_t c;
    c.chosen      = 1'b0;
    c.index       = '0;
    c.kind        = KIND_LINE;
    c.outcome     = OUTCOME_NOTHING;
    c.valid_count = passed;
    c.reason      = first_reason;
    if (tied) begin
      c.outcome = OUTCOME_AMBIG;
    end else if (special_seen) begin
      c.chosen  = 1'b1;
      c.index   = special_index;
      c.kind    = special_kind;
      c.outcome = OUTCOME_SPECIAL;
    end else if (line_seen) begin
      c.chosen  = 1'b1;
      c.index   = line_index;
      c.outcome = OUTCOME_LINE;
    end else if (first_reason != REASON_NONE) begin
      c.outcome = OUTCOME_NO_VALID;
    end
    expected_choices.push_back(c);
    clear_list();
  endtask

  always @(posedge clk) begin : watch
    choice_t want;
    if (!rst_n) begin
      special_floor = CONF_MIN_RESET;
      clear_list();
      expected_choices.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_choices.size() == 0) begin
          report_mismatch("result with none pending, outcome", out_outcome, 0);
        end else begin
          want = expected_choices.pop_front();
          if (out_selected_present !== want.chosen)
            report_mismatch("selected_present", out_selected_present, want.chosen);
          if (out_selected_index !== want.index)
            report_mismatch("selected_index", out_selected_index, want.index);
          if (out_selected_kind !== want.kind)
            report_mismatch("selected_kind", out_selected_kind, want.kind);
          if (out_outcome !== want.outcome)
            report_mismatch("outcome", out_outcome, want.outcome);
          if (out_valid_count !== want.valid_count)
            report_mismatch("valid_count", out_valid_count, want.valid_count);
          if (out_first_reject_reason !== want.reason)
            report_mismatch("first_reject_reason", out_first_reject_reason, want.reason);
        end
      end
      if (cfg_wr_en) special_floor = cfg_wr_data;
      if (in_valid && in_ready) begin
        // slots past the list limit are dropped but still close the list
        if (list_pos < LIST_LIMIT) begin
          if (in_present) begin
            fold_candidate(index_t'(list_pos), in_kind, in_confidence,
                           screen_candidate(in_confidence, in_confidence_nonfinite,
                                            in_path_mode, in_sample_present_mask,
                                            in_sample_nonfinite_mask));
          end
          list_pos++;
        end
        if (in_is_last) close_list();
      end
    end
    results_owed <= expected_choices.size();
  end

endmodule

[test/priority_confidence_reference_selector_tb.sv]
`timescale 1ns / 100ps

module priority_confidence_reference_selector_tb;
  import pcrs_pkg::*;

  localparam int IDLE_MAX    = 14;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 192;
  localparam int PHASES      = 6;

  localparam kind_t KIND_SPARE_6 = 3'd6;
  localparam kind_t KIND_SPARE_7 = 3'd7;
  localparam mode_t MODE_NO_PATH = 2'd2;
  localparam mode_t MODE_SPARE   = 2'd3;

  typedef struct {
    logic  present;
    kind_t kind;
    conf_t conf;
    logic  conf_bad;
    mode_t mode;
    mask_t sample_bits;
    mask_t broken_bits;
    logic  last;
  } candidate_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_wr_en = 1'b0;
  cfg_t     cfg_wr_data = '0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  logic     in_present = 1'b0;
  kind_t    in_kind = KIND_LINE;
  conf_t    in_confidence = '0;
  logic     in_confidence_nonfinite = 1'b0;
  mode_t    in_path_mode = MODE_INTERVAL_CENTER;
  mask_t    in_sample_present_mask = '0;
  mask_t    in_sample_nonfinite_mask = '0;
  logic     in_is_last = 1'b0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  logic     out_selected_present;
  index_t   out_selected_index;
  kind_t    out_selected_kind;
  outcome_t out_outcome;
  count_t   out_valid_count;
  reason_t  out_first_reject_reason;

  int   fail_count;
  int   results_owed;
  int   idle_cycles = 0;
  logic quiet = 1'b0;
  cfg_t cur_floor = CONF_MIN_RESET;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  priority_confidence_reference_selector DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_present              (in_present),
    .in_kind                 (in_kind),
    .in_confidence           (in_confidence),
    .in_confidence_nonfinite (in_confidence_nonfinite),
    .in_path_mode            (in_path_mode),
    .in_sample_present_mask  (in_sample_present_mask),
    .in_sample_nonfinite_mask(in_sample_nonfinite_mask),
    .in_is_last              (in_is_last),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_selected_present    (out_selected_present),
    .out_selected_index      (out_selected_index),
    .out_selected_kind       (out_selected_kind),
    .out_outcome             (out_outcome),
    .out_valid_count         (out_valid_count),
    .out_first_reject_reason (out_first_reject_reason)
  );

  reference_choice_checker choice_check (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_present              (in_present),
    .in_kind                 (in_kind),
    .in_confidence           (in_confidence),
    .in_confidence_nonfinite (in_confidence_nonfinite),
    .in_path_mode            (in_path_mode),
    .in_sample_present_mask  (in_sample_present_mask),
    .in_sample_nonfinite_mask(in_sample_nonfinite_mask),
    .in_is_last              (in_is_last),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_selected_present    (out_selected_present),
    .out_selected_index      (out_selected_index),
    .out_selected_kind       (out_selected_kind),
    .out_outcome             (out_outcome),
    .out_valid_count         (out_valid_count),
    .out_first_reject_reason (out_first_reject_reason),
    .fail_count              (fail_count),
    .results_owed            (results_owed)
  );

  // watchdog: too long without any item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic candidate_t well_formed(kind_t kind, conf_t conf, int samples, logic last);
    candidate_t c;
    c.present     = 1'b1;
    c.kind        = kind;
    c.conf        = conf;
    c.conf_bad    = 1'b0;
    c.mode        = MODE_INTERVAL_CENTER;
    c.sample_bits = mask_t'((32'd1 << samples) - 1);
    // nonfinite flags on absent samples are don't-care
    c.broken_bits = mask_t'($urandom) & ~c.sample_bits;
    c.last        = last;
    return c;
  endfunction

  function automatic conf_t pick_conf();
    case ($urandom_range(0, 6))
      0:       return conf_t'(0);
      1:       return conf_t'(65535);
      2:       return conf_t'({1'b0, cur_floor});
      3:       return conf_t'({1'b0, cur_floor} - (cur_floor != 0));
      4, 5:    return conf_t'(30000 + 10000 * $urandom_range(0, 2));
      default: return conf_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic candidate_t random_candidate(logic last);
    candidate_t c;
    int roll;
    int samples;
    roll    = $urandom_range(0, 99);
    samples = $urandom_range(1, 16);
    c = well_formed(kind_t'($urandom_range(0, 7)), pick_conf(), samples, last);
    c.present = ($urandom_range(0, 9) != 0);
    if (roll >= 90) begin
      c.present     = $urandom_range(0, 1);
      c.kind        = kind_t'($urandom);
      c.conf        = conf_t'($urandom);
      c.conf_bad    = $urandom_range(0, 1);
      c.mode        = mode_t'($urandom);
      c.sample_bits = mask_t'($urandom);
      c.broken_bits = mask_t'($urandom);
    end else if (roll >= 75) begin
      // otherwise sound candidate with a single defect
      case ($urandom_range(0, 6))
        0: c.conf = conf_t'(0 - int'($urandom_range(1, 65536)));
        1: c.conf_bad = 1'b1;
        2: c.mode = MODE_HOLD_LAST;
        3: c.mode = $urandom_range(0, 1) ? MODE_NO_PATH : MODE_SPARE;
        4: c.sample_bits = mask_t'($urandom) & ~mask_t'(1);
        5: begin
          samples = $urandom_range(1, 14);
          c.sample_bits = mask_t'((32'd1 << samples) - 1)
                        | (mask_t'(1) << $urandom_range(samples + 1, 15));
        end
        default: c.broken_bits[$urandom_range(0, samples - 1)] = 1'b1;
      endcase
    end
    return c;
  endfunction

  task automatic push_candidate(candidate_t c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid                 <= 1'b1;
    in_present               <= c.present;
    in_kind                  <= c.kind;
    in_confidence            <= c.conf;
    in_confidence_nonfinite  <= c.conf_bad;
    in_path_mode             <= c.mode;
    in_sample_present_mask   <= c.sample_bits;
    in_sample_nonfinite_mask <= c.broken_bits;
    in_is_last               <= c.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_floor(cfg_t value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    cur_floor    = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_lists(int budget, logic calm);
    int length;
    int sent;
    sent = 0;
    while (sent < budget) begin
      quiet  = calm || ($urandom_range(0, 7) == 0);
      // some lists run past the slot limit
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
      for (int i = 0; i < length; i++) push_candidate(random_candidate(i == length - 1));
      sent += length;
    end
  endtask

  initial begin : stimulus
    candidate_t c;
    cfg_t floors [PHASES];
    floors = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, CONF_MIN_RESET, cfg_t'($urandom)};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // line beats an absent slot and a special just under the threshold
    push_candidate(well_formed(KIND_LINE, conf_t'(1000), 16, 1'b0));
    c = well_formed(KIND_ROADBLOCK, conf_t'(65535), 16, 1'b0);
    c.present = 1'b0;
    push_candidate(c);
    push_candidate(well_formed(KIND_CROSS_EXIT, conf_t'(21298), 4, 1'b0));
    push_candidate(well_formed(KIND_LINE, conf_t'(65535), 8, 1'b1));

    // rank order, a tie cleared by a higher rank, spare kinds
    push_candidate(well_formed(KIND_CROSS_EXIT, conf_t'(30000), 16, 1'b0));
    push_candidate(well_formed(KIND_CIRCLE_LEFT, conf_t'(30000), 2, 1'b0));
    push_candidate(well_formed(KIND_CIRCLE_RIGHT, conf_t'(30000), 3, 1'b0));
    push_candidate(well_formed(KIND_ROADBLOCK, conf_t'(21299), 1, 1'b0));
    push_candidate(well_formed(KIND_ML_GROUNDED, conf_t'(65535), 5, 1'b0));
    push_candidate(well_formed(KIND_SPARE_6, conf_t'(65535), 6, 1'b0));
    push_candidate(well_formed(KIND_SPARE_7, conf_t'(40000), 2, 1'b1));

    // every rejection reason, nothing valid
    c = well_formed(KIND_ROADBLOCK, conf_t'(-65536), 16, 1'b0);
    push_candidate(c);
    c = well_formed(KIND_ROADBLOCK, conf_t'(50000), 16, 1'b0);
    c.conf_bad = 1'b1;
    push_candidate(c);
    c = well_formed(KIND_LINE, conf_t'(50000), 16, 1'b0);
    c.mode = MODE_HOLD_LAST;
    push_candidate(c);
    c.mode = MODE_NO_PATH;
    push_candidate(c);
    c.mode = MODE_SPARE;
    push_candidate(c);
    c = well_formed(KIND_LINE, conf_t'(50000), 16, 1'b0);
    c.sample_bits = 16'hFFFE;
    push_candidate(c);
    c.sample_bits = 16'h0005;
    push_candidate(c);
    c.sample_bits = 16'hFFFF;
    c.broken_bits = 16'h8000;
    c.last        = 1'b1;
    push_candidate(c);

    // equal confidence at equal rank
    push_candidate(well_formed(KIND_CIRCLE_LEFT, conf_t'(40000), 3, 1'b0));
    push_candidate(well_formed(KIND_CIRCLE_RIGHT, conf_t'(40000), 5, 1'b1));

    // list of a single absent slot
    c = well_formed(KIND_LINE, conf_t'(0), 1, 1'b1);
    c.present = 1'b0;
    push_candidate(c);
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_floor(floors[ph]);
      run_lists(PHASE_ITEMS, ph == 2);
      drain_results();
    end

    if (fail_count == 0 && results_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
